FILE: hw/rtl/drbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbr_pkg
// Shared types and constants of the drawbridge sequencer: request payloads,
// configuration set, sequence state and phase codes.
// ----------------------------------------------------------------------------
package drbr_pkg;

  // sequence phases, in the order the opening runs through them
  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_BEEP1_ON  = 5'd1,
    PH_BEEP1_OFF = 5'd2,
    PH_BEEP2_ON  = 5'd3,
    PH_BEEP2_OFF = 5'd4,
    PH_BARRIER   = 5'd5,
    PH_RAISE     = 5'd6,
    PH_TRAVEL    = 5'd7,
    PH_SAIL      = 5'd8,
    PH_HOLD      = 5'd9,
    PH_SETTLE1   = 5'd10,
    PH_LOWER     = 5'd11,
    PH_SETTLE2   = 5'd12,
    PH_BEEP3_ON  = 5'd13,
    PH_BEEP3_OFF = 5'd14,
    PH_BEEP4_ON  = 5'd15,
    PH_BEEP4_OFF = 5'd16,
    PH_LIFTBAR   = 5'd17
  } phase_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_WIND_LIMIT   = 3'd0,
    CFG_SHORT_TIME   = 3'd1,
    CFG_BARRIER_TIME = 3'd2,
    CFG_RAISE_TIME   = 3'd3,
    CFG_TRAVEL_TIME  = 3'd4,
    CFG_SAIL_TIME    = 3'd5,
    CFG_LOWER_TIME   = 3'd6,
    CFG_SETTLE_TIME  = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned LampW    = 6;

  // indicator lamp bit positions
  localparam int unsigned LampBoat    = 0;
  localparam int unsigned LampWind    = 1;
  localparam int unsigned LampSail    = 2;
  localparam int unsigned LampBarrier = 3;
  localparam int unsigned LampOpen    = 4;
  localparam int unsigned LampClosed  = 5;

  // deck motor commands
  localparam logic [1:0] DeckOff   = 2'd0;
  localparam logic [1:0] DeckRaise = 2'd1;
  localparam logic [1:0] DeckLower = 2'd2;

  // register reset values
  localparam logic [7:0]        WindLimitRst   = 8'd52;
  localparam logic [TimerW-1:0] ShortTimeRst   = 16'd200;
  localparam logic [TimerW-1:0] BarrierTimeRst = 16'd500;
  localparam logic [TimerW-1:0] RaiseTimeRst   = 16'd650;
  localparam logic [TimerW-1:0] TravelTimeRst  = 16'd1500;
  localparam logic [TimerW-1:0] SailTimeRst    = 16'd3000;
  localparam logic [TimerW-1:0] LowerTimeRst   = 16'd1600;
  localparam logic [TimerW-1:0] SettleTimeRst  = 16'd1000;

  typedef struct packed {
    logic       boat_rear;
    logic       boat_front;
    logic       end_stop;
    logic [7:0] wind_level;
  } in_item_t;

  typedef struct packed {
    logic             road_red;
    logic             water_rear_green;
    logic             water_front_green;
    logic [LampW-1:0] indicator_lamps;
    logic             buzzer_on;
    logic [1:0]       deck_motor;
    logic             barrier_down;
    logic             busy_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0]        wind_limit;
    logic [TimerW-1:0] short_time;
    logic [TimerW-1:0] barrier_time;
    logic [TimerW-1:0] raise_time;
    logic [TimerW-1:0] travel_time;
    logic [TimerW-1:0] sail_time;
    logic [TimerW-1:0] lower_time;
    logic [TimerW-1:0] settle_time;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [TimerW-1:0] phase_timer;
    logic              serving_front;
    logic              front_pending;
    logic              endstop_latch;
    logic [LampW-1:0]  lamp_bits;
    logic              barrier_state;
  } seq_state_t;

endpackage

FILE: hw/rtl/drawbridge_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drawbridge_sequencer_core
// Drawbridge opening sequencer driven by 1 ms tick requests.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------
//   in      | in        | in_valid_i / in_stall_o | in_data_i  (ticks)
//   out     | out       | out_valid_o / out_stall_i | out_data_o (signals)
//   cfg     | in        | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// One tick request per clock while in_stall_o is low; the state steps as a
// request moves from the input register into the result register.
// Reset clears the sequence state and loads the default durations.
// A stalled result holds the result register, the next one lands in the skid
// entry and a third waits in the input register with in_stall_o high.
// ----------------------------------------------------------------------------
module drawbridge_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  drbr_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output drbr_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  drbr_pkg::cfg_idx_e            cfg_index_i,
  input  logic [drbr_pkg::CfgDataW-1:0] cfg_wdata_i
);

  drbr_pkg::cfg_t       cfg;
  drbr_pkg::seq_state_t state_q, state_d;
  drbr_pkg::in_item_t   item_q;
  drbr_pkg::out_item_t  result;
  logic                 in_valid_q, in_valid_d;
  logic                 obuf_full;
  logic                 fire;
  logic                 in_take;

  drbr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register handshake
  assign fire       = in_valid_q && !obuf_full;
  assign in_stall_o = in_valid_q && obuf_full;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  // tick step logic
  drbr_step u_step (
    .state_i  (state_q),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (result)
  );

  // sequence state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= drbr_pkg::PH_IDLE;
      state_q.phase_timer   <= '0;
      state_q.serving_front <= 1'b0;
      state_q.front_pending <= 1'b0;
      state_q.endstop_latch <= 1'b0;
      state_q.lamp_bits     <= '0;
      state_q.barrier_state <= 1'b0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  drbr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_data_i (result),
    .full_o      (obuf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hw/rtl/drbr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbr_cfg
// Configuration register file: wind limit and the phase durations.
// ----------------------------------------------------------------------------
module drbr_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  drbr_pkg::cfg_idx_e             cfg_index_i,
  input  logic [drbr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output drbr_pkg::cfg_t                 cfg_o
);

  drbr_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        drbr_pkg::CFG_WIND_LIMIT:   cfg_d.wind_limit   = cfg_wdata_i[7:0];
        drbr_pkg::CFG_SHORT_TIME:   cfg_d.short_time   = cfg_wdata_i;
        drbr_pkg::CFG_BARRIER_TIME: cfg_d.barrier_time = cfg_wdata_i;
        drbr_pkg::CFG_RAISE_TIME:   cfg_d.raise_time   = cfg_wdata_i;
        drbr_pkg::CFG_TRAVEL_TIME:  cfg_d.travel_time  = cfg_wdata_i;
        drbr_pkg::CFG_SAIL_TIME:    cfg_d.sail_time    = cfg_wdata_i;
        drbr_pkg::CFG_LOWER_TIME:   cfg_d.lower_time   = cfg_wdata_i;
        drbr_pkg::CFG_SETTLE_TIME:  cfg_d.settle_time  = cfg_wdata_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wind_limit   <= drbr_pkg::WindLimitRst;
      cfg_q.short_time   <= drbr_pkg::ShortTimeRst;
      cfg_q.barrier_time <= drbr_pkg::BarrierTimeRst;
      cfg_q.raise_time   <= drbr_pkg::RaiseTimeRst;
      cfg_q.travel_time  <= drbr_pkg::TravelTimeRst;
      cfg_q.sail_time    <= drbr_pkg::SailTimeRst;
      cfg_q.lower_time   <= drbr_pkg::LowerTimeRst;
      cfg_q.settle_time  <= drbr_pkg::SettleTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/drbr_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbr_step
// Next-state and result logic for one tick of the opening sequence.
// ----------------------------------------------------------------------------
module drbr_step (
  input  drbr_pkg::seq_state_t state_i,
  input  drbr_pkg::in_item_t   item_i,
  input  drbr_pkg::cfg_t       cfg_i,
  output drbr_pkg::seq_state_t state_o,
  output drbr_pkg::out_item_t  result_o
);

  logic [drbr_pkg::TimerW-1:0] dur_raw;
  logic [drbr_pkg::TimerW-1:0] dur;
  logic [drbr_pkg::TimerW-1:0] timer_inc;
  logic                        wind_ok;
  logic                        is_idle;
  drbr_pkg::phase_e            next_ph;
  drbr_pkg::seq_state_t        s;

  // duration of the current phase, zero counts as one tick
  always_comb begin
    unique case (state_i.phase)
      drbr_pkg::PH_BARRIER,
      drbr_pkg::PH_LIFTBAR: dur_raw = cfg_i.barrier_time;
      drbr_pkg::PH_RAISE:   dur_raw = cfg_i.raise_time;
      drbr_pkg::PH_TRAVEL:  dur_raw = cfg_i.travel_time;
      drbr_pkg::PH_SAIL:    dur_raw = cfg_i.sail_time;
      drbr_pkg::PH_SETTLE1,
      drbr_pkg::PH_SETTLE2: dur_raw = cfg_i.settle_time;
      drbr_pkg::PH_LOWER:   dur_raw = cfg_i.lower_time;
      default:              dur_raw = cfg_i.short_time;
    endcase
  end

  assign dur       = (dur_raw == '0) ? {{(drbr_pkg::TimerW-1){1'b0}}, 1'b1} : dur_raw;
  assign timer_inc = state_i.phase_timer + {{(drbr_pkg::TimerW-1){1'b0}}, 1'b1};
  assign wind_ok   = (item_i.wind_level <= cfg_i.wind_limit);
  assign is_idle   = (state_i.phase == drbr_pkg::PH_IDLE) ||
                     (state_i.phase > drbr_pkg::PH_LIFTBAR);
  assign next_ph   = drbr_pkg::phase_e'(state_i.phase + 5'd1);

  // phase stepping and lamp updates
  always_comb begin
    s = state_i;
    if (is_idle) begin
      s.phase       = drbr_pkg::PH_IDLE;
      s.phase_timer = '0;
      s.lamp_bits[drbr_pkg::LampOpen]   = ~item_i.end_stop;
      s.lamp_bits[drbr_pkg::LampClosed] = item_i.end_stop;
      s.endstop_latch = item_i.end_stop;
      s.front_pending = 1'b0;
      if (item_i.boat_rear || item_i.boat_front) begin
        s.lamp_bits[drbr_pkg::LampBoat] = 1'b1;
        if (wind_ok) begin
          // rear side is served first, front remembered
          s.serving_front = ~item_i.boat_rear;
          s.front_pending = item_i.boat_rear & item_i.boat_front;
          s.phase         = drbr_pkg::PH_BEEP1_ON;
        end else begin
          s.lamp_bits[drbr_pkg::LampWind] = 1'b1;
        end
      end
    end else if (timer_inc >= dur) begin
      s.phase_timer = '0;
      if (state_i.phase == drbr_pkg::PH_LIFTBAR) begin
        // sequence done, maybe start the pending front side
        s.lamp_bits[drbr_pkg::LampBarrier] = 1'b0;
        s.lamp_bits[drbr_pkg::LampBoat]    = 1'b0;
        s.barrier_state = 1'b0;
        s.phase         = drbr_pkg::PH_IDLE;
        if (state_i.front_pending) begin
          s.front_pending = 1'b0;
          s.lamp_bits[drbr_pkg::LampBoat] = 1'b1;
          if (wind_ok) begin
            s.serving_front = 1'b1;
            s.phase         = drbr_pkg::PH_BEEP1_ON;
          end else begin
            s.lamp_bits[drbr_pkg::LampWind] = 1'b1;
          end
        end
      end else begin
        s.phase = next_ph;
        unique case (next_ph)
          drbr_pkg::PH_BARRIER: begin
            s.barrier_state = 1'b1;
            s.lamp_bits[drbr_pkg::LampBarrier] = 1'b1;
          end
          drbr_pkg::PH_TRAVEL: begin
            s.lamp_bits[drbr_pkg::LampClosed] = 1'b0;
            s.lamp_bits[drbr_pkg::LampOpen]   = 1'b1;
          end
          drbr_pkg::PH_SAIL: begin
            s.lamp_bits[drbr_pkg::LampSail] = 1'b1;
          end
          drbr_pkg::PH_SETTLE1: begin
            s.lamp_bits[drbr_pkg::LampSail] = 1'b0;
          end
          drbr_pkg::PH_SETTLE2: begin
            s.lamp_bits[drbr_pkg::LampOpen]   = ~state_i.endstop_latch;
            s.lamp_bits[drbr_pkg::LampClosed] = state_i.endstop_latch;
          end
          drbr_pkg::PH_LIFTBAR: begin
            s.barrier_state = 1'b0;
          end
          default: begin
            s.barrier_state = state_i.barrier_state;
          end
        endcase
      end
    end else begin
      s.phase_timer = timer_inc;
    end
  end

  assign state_o = s;

  // result decode from the new phase
  always_comb begin
    result_o.road_red = (s.phase >= drbr_pkg::PH_BARRIER) &&
                        (s.phase <= drbr_pkg::PH_LIFTBAR);
    result_o.water_rear_green  = (s.phase == drbr_pkg::PH_SAIL) && !s.serving_front;
    result_o.water_front_green = (s.phase == drbr_pkg::PH_SAIL) && s.serving_front;
    result_o.indicator_lamps   = s.lamp_bits;
    result_o.buzzer_on = (s.phase == drbr_pkg::PH_BEEP1_ON) ||
                         (s.phase == drbr_pkg::PH_BEEP2_ON) ||
                         (s.phase == drbr_pkg::PH_BEEP3_ON) ||
                         (s.phase == drbr_pkg::PH_BEEP4_ON);
    if ((s.phase >= drbr_pkg::PH_RAISE) && (s.phase <= drbr_pkg::PH_SETTLE1)) begin
      result_o.deck_motor = drbr_pkg::DeckRaise;
    end else if (s.phase == drbr_pkg::PH_LOWER) begin
      result_o.deck_motor = drbr_pkg::DeckLower;
    end else begin
      result_o.deck_motor = drbr_pkg::DeckOff;
    end
    result_o.barrier_down = s.barrier_state;
    result_o.busy_res     = (s.phase != drbr_pkg::PH_IDLE);
  end

endmodule

FILE: hw/rtl/drbr_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbr_obuf
// Result register with a skid entry, so a stalled result does not hold up
// the tick already in flight.
// ----------------------------------------------------------------------------
module drbr_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  drbr_pkg::out_item_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output drbr_pkg::out_item_t out_data_o
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  drbr_pkg::out_item_t out_data_q, out_data_d;
  drbr_pkg::out_item_t skid_data_q, skid_data_d;
  logic                pop;

  assign pop = out_valid_q && !out_stall_i;

  // result and skid steering
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (push_i) begin
      if (!out_valid_q || (pop && !skid_valid_q)) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: tb/drawbridge_sequencer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drawbridge_sequencer_core_test
// Self-checking bench for the drawbridge sequencer. Tick requests come from a
// queue and go through a valid/stall driver. A predictor of the opening
// sequence steps on every accepted request, and a monitor compares every
// result field by field. Both sides idle and stall in random bursts. The run
// covers the reset wind limit, a duration shortened while its phase runs,
// tiny and zero durations, both wind limit extremes and random settings.
// ----------------------------------------------------------------------------
module drawbridge_sequencer_core_test;

  // content of the ticks that keep a running sequence fed
  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_CALM,
    FILL_GUSTY
  } fill_e;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  drbr_pkg::in_item_t            in_data_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  drbr_pkg::out_item_t           out_data_o;
  logic                          cfg_we_i    = 1'b0;
  drbr_pkg::cfg_idx_e            cfg_index_i = drbr_pkg::CFG_WIND_LIMIT;
  logic [drbr_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  // predictor state and register copy
  drbr_pkg::seq_state_t bridge_st;
  drbr_pkg::cfg_t       bridge_cfg;

  drbr_pkg::in_item_t  tick_q[$];
  drbr_pkg::out_item_t signal_q[$];
  int unsigned         mismatches = 0;
  bit                  quiet = 1'b0;
  int unsigned         tx_gap = 0;
  int unsigned         rx_gap = 0;
  int unsigned         rx_hold_left = 0;
  int unsigned         hold_asked = 0;
  int unsigned         hold_done = 0;
  drbr_pkg::out_item_t want;

  drawbridge_sequencer_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ticks each phase lasts, zero counts as one
  function automatic logic [drbr_pkg::TimerW-1:0] dwell(drbr_pkg::phase_e p);
    logic [drbr_pkg::TimerW-1:0] d;
    case (p)
      drbr_pkg::PH_BARRIER, drbr_pkg::PH_LIFTBAR: d = bridge_cfg.barrier_time;
      drbr_pkg::PH_RAISE:                         d = bridge_cfg.raise_time;
      drbr_pkg::PH_TRAVEL:                        d = bridge_cfg.travel_time;
      drbr_pkg::PH_SAIL:                          d = bridge_cfg.sail_time;
      drbr_pkg::PH_SETTLE1, drbr_pkg::PH_SETTLE2: d = bridge_cfg.settle_time;
      drbr_pkg::PH_LOWER:                         d = bridge_cfg.lower_time;
      default:                                    d = bridge_cfg.short_time;
    endcase
    if (d == '0) d = drbr_pkg::TimerW'(1);
    return d;
  endfunction

  function automatic void enter_phase(drbr_pkg::phase_e p);
    bridge_st.phase = p;
    bridge_st.phase_timer = '0;
    case (p)
      drbr_pkg::PH_BARRIER: begin
        bridge_st.barrier_state = 1'b1;
        bridge_st.lamp_bits[drbr_pkg::LampBarrier] = 1'b1;
      end
      drbr_pkg::PH_TRAVEL: begin
        bridge_st.lamp_bits[drbr_pkg::LampClosed] = 1'b0;
        bridge_st.lamp_bits[drbr_pkg::LampOpen] = 1'b1;
      end
      drbr_pkg::PH_SAIL:    bridge_st.lamp_bits[drbr_pkg::LampSail] = 1'b1;
      drbr_pkg::PH_SETTLE1: bridge_st.lamp_bits[drbr_pkg::LampSail] = 1'b0;
      drbr_pkg::PH_SETTLE2: begin
        bridge_st.lamp_bits[drbr_pkg::LampOpen] = !bridge_st.endstop_latch;
        bridge_st.lamp_bits[drbr_pkg::LampClosed] = bridge_st.endstop_latch;
      end
      drbr_pkg::PH_LIFTBAR: bridge_st.barrier_state = 1'b0;
      default: ;
    endcase
  endfunction

  // boat seen on one side: open if calm enough, else light the wind lamp
  function automatic bit try_open(bit front, logic [7:0] wind);
    bridge_st.lamp_bits[drbr_pkg::LampBoat] = 1'b1;
    if (wind <= bridge_cfg.wind_limit) begin
      bridge_st.serving_front = front;
      enter_phase(drbr_pkg::PH_BEEP1_ON);
      return 1'b1;
    end
    bridge_st.lamp_bits[drbr_pkg::LampWind] = 1'b1;
    return 1'b0;
  endfunction

  // one tick of the sequencer, returns the signals it shows
  function automatic drbr_pkg::out_item_t step_bridge(drbr_pkg::in_item_t t);
    drbr_pkg::out_item_t r;
    drbr_pkg::phase_e    p;
    if (bridge_st.phase == drbr_pkg::PH_IDLE || bridge_st.phase > drbr_pkg::PH_LIFTBAR) begin
      bridge_st.phase = drbr_pkg::PH_IDLE;
      bridge_st.phase_timer = '0;
      bridge_st.lamp_bits[drbr_pkg::LampOpen] = !t.end_stop;
      bridge_st.lamp_bits[drbr_pkg::LampClosed] = t.end_stop;
      bridge_st.endstop_latch = t.end_stop;
      bridge_st.front_pending = 1'b0;
      if (t.boat_rear) begin
        if (try_open(1'b0, t.wind_level)) bridge_st.front_pending = t.boat_front;
        else if (t.boat_front) void'(try_open(1'b1, t.wind_level));
      end else if (t.boat_front) begin
        void'(try_open(1'b1, t.wind_level));
      end
    end else begin
      bridge_st.phase_timer = bridge_st.phase_timer + 1'b1;
      if (bridge_st.phase_timer >= dwell(bridge_st.phase)) begin
        if (bridge_st.phase == drbr_pkg::PH_LIFTBAR) begin
          bridge_st.lamp_bits[drbr_pkg::LampBarrier] = 1'b0;
          bridge_st.lamp_bits[drbr_pkg::LampBoat] = 1'b0;
          bridge_st.barrier_state = 1'b0;
          bridge_st.phase = drbr_pkg::PH_IDLE;
          bridge_st.phase_timer = '0;
          // a waiting front boat is decided by this tick's wind
          if (bridge_st.front_pending) begin
            bridge_st.front_pending = 1'b0;
            void'(try_open(1'b1, t.wind_level));
          end
        end else begin
          enter_phase(drbr_pkg::phase_e'(bridge_st.phase + 1));
        end
      end
    end
    p = bridge_st.phase;
    r.road_red = (p >= drbr_pkg::PH_BARRIER && p <= drbr_pkg::PH_LIFTBAR);
    r.water_rear_green = (p == drbr_pkg::PH_SAIL && !bridge_st.serving_front);
    r.water_front_green = (p == drbr_pkg::PH_SAIL && bridge_st.serving_front);
    r.indicator_lamps = bridge_st.lamp_bits;
    r.buzzer_on = p inside {drbr_pkg::PH_BEEP1_ON, drbr_pkg::PH_BEEP2_ON,
                            drbr_pkg::PH_BEEP3_ON, drbr_pkg::PH_BEEP4_ON};
    r.deck_motor = (p >= drbr_pkg::PH_RAISE && p <= drbr_pkg::PH_SETTLE1) ? drbr_pkg::DeckRaise :
                   (p == drbr_pkg::PH_LOWER) ? drbr_pkg::DeckLower : drbr_pkg::DeckOff;
    r.barrier_down = bridge_st.barrier_state;
    r.busy_res = (p != drbr_pkg::PH_IDLE);
    return r;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) signal_q.push_back(step_bridge(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= tick_q.pop_front();
          if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 16);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic cmp(string name, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // result monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (signal_q.size() == 0) begin
          $error("result with no request waiting");
          mismatches++;
        end else begin
          want = signal_q.pop_front();
          cmp("road_red", want.road_red, out_data_o.road_red);
          cmp("water_rear_green", want.water_rear_green, out_data_o.water_rear_green);
          cmp("water_front_green", want.water_front_green, out_data_o.water_front_green);
          cmp("indicator_lamps", want.indicator_lamps, out_data_o.indicator_lamps);
          cmp("buzzer_on", want.buzzer_on, out_data_o.buzzer_on);
          cmp("deck_motor", want.deck_motor, out_data_o.deck_motor);
          cmp("barrier_down", want.barrier_down, out_data_o.barrier_down);
          cmp("busy_res", want.busy_res, out_data_o.busy_res);
        end
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_asked != hold_done) begin
        // long hold-off so the core fills up and stalls its input
        hold_done++;
        rx_hold_left = 400;
        out_stall_i <= 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        rx_gap = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_tick(bit rear, bit front, bit stop, logic [7:0] wind);
    drbr_pkg::in_item_t t;
    t.boat_rear = rear;
    t.boat_front = front;
    t.end_stop = stop;
    t.wind_level = wind;
    tick_q.push_back(t);
  endtask

  // keep a running sequence fed until the core is back at rest
  task automatic run_until_idle(fill_e mode);
    drbr_pkg::in_item_t f;
    @(negedge clk_i);
    while (!(bridge_st.phase == drbr_pkg::PH_IDLE && tick_q.size() == 0 && !in_valid_i)) begin
      if (bridge_st.phase != drbr_pkg::PH_IDLE && tick_q.size() < 2) begin
        f.boat_rear = ($urandom_range(0, 15) == 0);
        f.boat_front = ($urandom_range(0, 15) == 0);
        f.end_stop = 1'($urandom_range(0, 1));
        f.wind_level = 8'($urandom_range(0, 255));
        if (mode != FILL_RANDOM) begin
          f.boat_rear = 1'b0;
          f.boat_front = 1'b0;
          f.wind_level = (mode == FILL_GUSTY) ? 8'd255 : 8'd0;
        end
        tick_q.push_back(f);
      end
      @(negedge clk_i);
    end
  endtask

  // sender waits for every result, then for the pipeline to empty
  task automatic drain();
    @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || signal_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_reg(drbr_pkg::cfg_idx_e idx, logic [drbr_pkg::CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      drbr_pkg::CFG_WIND_LIMIT:   bridge_cfg.wind_limit = val[7:0];
      drbr_pkg::CFG_SHORT_TIME:   bridge_cfg.short_time = val;
      drbr_pkg::CFG_BARRIER_TIME: bridge_cfg.barrier_time = val;
      drbr_pkg::CFG_RAISE_TIME:   bridge_cfg.raise_time = val;
      drbr_pkg::CFG_TRAVEL_TIME:  bridge_cfg.travel_time = val;
      drbr_pkg::CFG_SAIL_TIME:    bridge_cfg.sail_time = val;
      drbr_pkg::CFG_LOWER_TIME:   bridge_cfg.lower_time = val;
      drbr_pkg::CFG_SETTLE_TIME:  bridge_cfg.settle_time = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(logic [drbr_pkg::CfgDataW-1:0] limit,
                       logic [drbr_pkg::CfgDataW-1:0] beep,
                       logic [drbr_pkg::CfgDataW-1:0] barrier,
                       logic [drbr_pkg::CfgDataW-1:0] raise,
                       logic [drbr_pkg::CfgDataW-1:0] travel,
                       logic [drbr_pkg::CfgDataW-1:0] sail,
                       logic [drbr_pkg::CfgDataW-1:0] lower,
                       logic [drbr_pkg::CfgDataW-1:0] settle);
    set_reg(drbr_pkg::CFG_WIND_LIMIT, limit);
    set_reg(drbr_pkg::CFG_SHORT_TIME, beep);
    set_reg(drbr_pkg::CFG_BARRIER_TIME, barrier);
    set_reg(drbr_pkg::CFG_RAISE_TIME, raise);
    set_reg(drbr_pkg::CFG_TRAVEL_TIME, travel);
    set_reg(drbr_pkg::CFG_SAIL_TIME, sail);
    set_reg(drbr_pkg::CFG_LOWER_TIME, lower);
    set_reg(drbr_pkg::CFG_SETTLE_TIME, settle);
  endtask

  // stimulus
  initial begin
    int          wind;
    int unsigned sides;
    bridge_st = '0;
    bridge_cfg.wind_limit = drbr_pkg::WindLimitRst;
    bridge_cfg.short_time = drbr_pkg::ShortTimeRst;
    bridge_cfg.barrier_time = drbr_pkg::BarrierTimeRst;
    bridge_cfg.raise_time = drbr_pkg::RaiseTimeRst;
    bridge_cfg.travel_time = drbr_pkg::TravelTimeRst;
    bridge_cfg.sail_time = drbr_pkg::SailTimeRst;
    bridge_cfg.lower_time = drbr_pkg::LowerTimeRst;
    bridge_cfg.settle_time = drbr_pkg::SettleTimeRst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: panel follows end stop, wind just over the limit
    push_tick(1'b0, 1'b0, 1'b0, 8'd0);
    push_tick(1'b0, 1'b0, 1'b1, 8'd255);
    push_tick(1'b1, 1'b0, 1'b0, 8'd53);
    push_tick(1'b0, 1'b1, 1'b1, 8'd255);
    push_tick(1'b0, 1'b0, 1'b0, 8'd0);
    // both boats right at the limit, first beep runs on the reset duration
    hold_asked++;
    push_tick(1'b1, 1'b1, 1'b1, 8'd52);
    for (int n = 0; n < 60; n++) push_tick(1'b0, 1'b0, n[0], 8'd0);
    drain();
    // shorter durations while the first beep is running
    setup(16'd52, 16'd2, 16'd1, 16'd2, 16'd1, 16'd3, 16'd2, 16'd1);
    run_until_idle(FILL_CALM);
    drain();

    // zero and one tick durations, calm only
    setup(16'd0, 16'd0, 16'd1, 16'd2, 16'd0, 16'd3, 16'd1, 16'd2);
    push_tick(1'b1, 1'b0, 1'b0, 8'd0);
    run_until_idle(FILL_RANDOM);
    push_tick(1'b0, 1'b1, 1'b1, 8'd0);
    run_until_idle(FILL_RANDOM);
    // front boat waiting behind the rear one meets a gust at the end
    push_tick(1'b1, 1'b1, 1'b0, 8'd0);
    run_until_idle(FILL_GUSTY);
    push_tick(1'b0, 1'b0, 1'b1, 8'd0);
    push_tick(1'b1, 1'b0, 1'b0, 8'd1);
    push_tick(1'b1, 1'b1, 1'b1, 8'd200);
    push_tick(1'b0, 1'b1, 1'b0, 8'd255);
    push_tick(1'b0, 1'b0, 1'b0, 8'd0);
    run_until_idle(FILL_RANDOM);
    drain();

    // any wind accepted, longer water green
    setup(16'd255, 16'd1, 16'd1, 16'd1, 16'd1, 16'd40, 16'd1, 16'd1);
    push_tick(1'b1, 1'b0, 1'b1, 8'd255);
    run_until_idle(FILL_CALM);
    drain();

    // random settings, the last one without idling
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) quiet = 1'b1;
      setup(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 2)),
            16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
            16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)),
            16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)));
      if (ph == 1) hold_asked++;
      for (int n = 0; n < 5; n++) begin
        sides = $urandom_range(0, 3);
        wind = int'(bridge_cfg.wind_limit) + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 2) == 0) wind = $urandom_range(0, 255);
        if (wind < 0) wind = 0;
        if (wind > 255) wind = 255;
        push_tick(sides[0], sides[1], 1'($urandom_range(0, 1)), wind[7:0]);
        run_until_idle(FILL_RANDOM);
      end
      drain();
    end

    // let the last results arrive, bounded
    for (int w = 0; w < 200 && signal_q.size() != 0; w++) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0 && signal_q.size() == 0) begin
      $display("** drawbridge_sequencer_core: PASSED **");
    end else begin
      $display("** drawbridge_sequencer_core: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("** drawbridge_sequencer_core: FAILED **");
    $finish;
  end

endmodule
